FILE: sv/text_word_normalizer_unit_macros.svh
// Assertion helpers for the normalizer RTL.
`ifndef TEXT_WORD_NORMALIZER_UNIT_MACROS_SVH
`define TEXT_WORD_NORMALIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TWN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("normalizer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TWN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("normalizer check failed");

`endif

FILE: sv/twn_pkg.sv
package twn_pkg;

  localparam int MAX_WORD_DEF = 32;
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = 1;

  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PERIOD   = 8'h2E;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  // Input byte classes
  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_ADD,
    CLS_SPACE,
    CLS_SENT,
    CLS_FLUSH
  } twn_class_t;

  // Tail written after the word
  typedef enum logic [1:0] {
    SFX_SPACE,
    SFX_SENT,
    SFX_PERIOD
  } twn_sfx_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_SEND
  } twn_bstate_t;

  // Emit command from front to back
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    twn_sfx_t         sfx;
  } twn_cmd_t;

  // Word bank handed back to the front
  typedef struct packed {
    logic valid;
    logic bank;
  } twn_rel_t;

  function automatic twn_class_t classify(input logic op, input logic [BYTE_W-1:0] c);
    twn_class_t r;
    if (op) begin
      r = CLS_FLUSH;
    end else begin
      unique case (c) inside
        [8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
        8'h40, 8'h24, 8'h23, 8'h2B, 8'h3C, 8'h3E, 8'h3D, 8'h2F: r = CLS_ADD;
        8'h20:                      r = CLS_SPACE;
        8'h3B, 8'h2E, 8'h21, 8'h3F: r = CLS_SENT;
        default:                    r = CLS_SKIP;
      endcase
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + CASE_OFFSET;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [1:0] sfx_len(input twn_sfx_t s);
    logic [1:0] r;
    unique case (s)
      SFX_SENT:   r = 2'd3;
      SFX_PERIOD: r = 2'd2;
      default:    r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] sfx_char(input twn_sfx_t s, input logic [1:0] j);
    logic [BYTE_W-1:0] r;
    unique case (s)
      SFX_SENT:   r = (j == 2'd1) ? CH_PERIOD : CH_SPACE;
      SFX_PERIOD: r = (j == 2'd0) ? CH_PERIOD : CH_SPACE;
      default:    r = CH_SPACE;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/twn_fifo.sv
module twn_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  twn_pkg::twn_cmd_t push_cmd,
  input  logic            pop,
  output twn_pkg::twn_cmd_t pop_cmd,
  output logic            full,
  output logic            empty
);
  import twn_pkg::*;

  twn_cmd_t             entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]     cnt_r, cnt_nxt;

  assign full    = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/twn_front.sv
module twn_front #(
  parameter int MAX_WORD = twn_pkg::MAX_WORD_DEF,
  parameter int IDX_W    = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic [twn_pkg::BYTE_W-1:0] in_byte,
  input  logic                      q_full,
  output logic                      q_push,
  output twn_pkg::twn_cmd_t         q_cmd,
  input  twn_pkg::twn_rel_t         rel,
  output logic                      wr_en,
  output logic [IDX_W:0]            wr_addr,
  output logic [twn_pkg::BYTE_W-1:0] wr_data
);
  import twn_pkg::*;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             letters_r, letters_nxt;
  logic             ovf_r, ovf_nxt;
  logic             earlier_r, earlier_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;

  twn_class_t       cls;
  logic [BYTE_W-1:0] ch;
  logic             accept;
  logic             word_ok;
  logic [1:0]       set_mask, clr_mask;

  // Hold input while the queue is full or the open bank is not yet released by the back
  assign in_stall = q_full || busy_r[bank_r];
  assign accept   = in_valid && !in_stall;
  assign cls      = classify(in_operation, in_byte);
  assign ch       = to_lower(in_byte);
  assign word_ok  = (len_r != '0) && letters_r && !ovf_r;
  assign wr_addr  = {bank_r, len_r[IDX_W-1:0]};
  assign wr_data  = ch;

  // Classify the byte and update the word state
  always_comb begin
    len_nxt     = len_r;
    letters_nxt = letters_r;
    ovf_nxt     = ovf_r;
    earlier_nxt = earlier_r;
    bank_nxt    = bank_r;
    q_push      = 1'b0;
    q_cmd       = '{bank: bank_r, len: len_r, sfx: SFX_SPACE};
    wr_en       = 1'b0;
    set_mask    = '0;
    if (accept) begin
      case (cls)
        CLS_ADD: begin
          if (ch < 8'h61 || ch > 8'h7A) begin
            letters_nxt = 1'b0;
          end
          if (len_r >= LEN_W'(MAX_WORD)) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en   = 1'b1;
            len_nxt = len_r + 1'b1;
          end
        end
        CLS_SPACE: begin
          if (word_ok) begin
            q_push      = 1'b1;
            earlier_nxt = 1'b1;
          end
        end
        CLS_SENT: begin
          if (word_ok) begin
            q_push    = 1'b1;
            q_cmd.sfx = SFX_SENT;
          end else if (earlier_r) begin
            q_push    = 1'b1;
            q_cmd.len = '0;
            q_cmd.sfx = SFX_PERIOD;
          end
          earlier_nxt = 1'b0;
        end
        CLS_FLUSH: begin
          if (len_r != '0) begin
            if (word_ok) begin
              q_push    = 1'b1;
              q_cmd.sfx = SFX_SENT;
            end
          end else if (earlier_r) begin
            q_push    = 1'b1;
            q_cmd.sfx = SFX_PERIOD;
          end
          earlier_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      // Clear the word on any boundary
      if (cls == CLS_SPACE || cls == CLS_SENT || cls == CLS_FLUSH) begin
        len_nxt     = '0;
        letters_nxt = 1'b1;
        ovf_nxt     = 1'b0;
      end
      // A queued word locks its bank; continue in the other one
      if (q_push && q_cmd.len != '0) begin
        set_mask[bank_r] = 1'b1;
        bank_nxt         = ~bank_r;
      end
    end
  end

  // Release banks the back has finished
  always_comb begin
    clr_mask = '0;
    if (rel.valid) begin
      clr_mask[rel.bank] = 1'b1;
    end
    busy_nxt = (busy_r & ~clr_mask) | set_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      letters_r <= 1'b1;
      ovf_r     <= 1'b0;
      earlier_r <= 1'b0;
      bank_r    <= 1'b0;
      busy_r    <= '0;
    end else begin
      len_r     <= len_nxt;
      letters_r <= letters_nxt;
      ovf_r     <= ovf_nxt;
      earlier_r <= earlier_nxt;
      bank_r    <= bank_nxt;
      busy_r    <= busy_nxt;
    end
  end

endmodule

FILE: sv/twn_back.sv
module twn_back #(
  parameter int IDX_W = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [IDX_W:0]            wr_addr,
  input  logic [twn_pkg::BYTE_W-1:0] wr_data,
  input  logic                      q_empty,
  input  twn_pkg::twn_cmd_t         q_cmd,
  output logic                      q_pop,
  output twn_pkg::twn_rel_t         rel,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [twn_pkg::BYTE_W-1:0] out_byte,
  output logic                      out_last_of_run
);
  import twn_pkg::*;

  logic [BYTE_W-1:0] mem [2**(IDX_W+1)];
  logic [BYTE_W-1:0] rd_data_r;
  logic [IDX_W:0]    rd_addr;

  twn_bstate_t       st_r, st_nxt;
  twn_cmd_t          cmd_r, cmd_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              ol_r, ol_nxt;

  logic [LEN_W-1:0]  total;
  logic [LEN_W-1:0]  j;
  logic              last;
  logic              out_free;
  logic              load;
  logic [BYTE_W-1:0] byte_sel;

  // Word banks: written by the front, read here
  assign rd_addr = {cmd_r.bank, k_r[IDX_W-1:0]};
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign total    = cmd_r.len + LEN_W'(sfx_len(cmd_r.sfx));
  assign j        = k_r - cmd_r.len;
  assign last     = (k_r == total - 1'b1);
  assign out_free = !ov_r || !out_stall;
  assign byte_sel = (k_r < cmd_r.len) ? rd_data_r : sfx_char(cmd_r.sfx, j[1:0]);

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE:  if (!q_empty) st_nxt = B_FETCH;
      B_FETCH: st_nxt = B_SEND;
      B_SEND: begin
        if (out_free) begin
          st_nxt = last ? B_IDLE : B_FETCH;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // Pop commands, step through bytes, load the output register
  always_comb begin
    q_pop     = (st_r == B_IDLE) && !q_empty;
    load      = (st_r == B_SEND) && out_free;
    cmd_nxt   = q_pop ? q_cmd : cmd_r;
    k_nxt     = q_pop ? '0 : (load ? k_r + 1'b1 : k_r);
    rel.valid = load && last && (cmd_r.len != '0);
    rel.bank  = cmd_r.bank;
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    if (load) begin
      ov_nxt = 1'b1;
      ob_nxt = byte_sel;
      ol_nxt = last;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    k_r   <= k_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_last_of_run = ol_r;

endmodule

FILE: sv/text_word_normalizer_unit.sv
// Text word normalizer: takes one raw byte (or an end-of-stream mark) per
// transfer and produces lowercase words separated by single spaces, with
// sentence ends written as " . ". Every emitted byte is one output transfer;
// the final byte caused by an input item carries out_last_of_run. The front
// accepts one item per cycle while not stalled and writes word letters into
// one of two word banks; words to emit go through a two-entry command queue
// to the back, which pops a command when idle and then sends it byte by byte
// (bank read, then output register load), holding while the output is stalled
// and taking the next command only after the last byte. The front holds
// input only when the queue is full or both banks wait to be sent.
`include "text_word_normalizer_unit_macros.svh"

module text_word_normalizer_unit #(
  parameter int MAX_WORD = twn_pkg::MAX_WORD_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic [twn_pkg::BYTE_W-1:0] in_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [twn_pkg::BYTE_W-1:0] out_byte,
  output logic                      out_last_of_run
);
  import twn_pkg::*;

  localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  logic              q_full, q_empty, q_push, q_pop;
  twn_cmd_t          q_in_cmd, q_out_cmd;
  twn_rel_t          rel;
  logic              wr_en;
  logic [IDX_W:0]    wr_addr;
  logic [BYTE_W-1:0] wr_data;

  twn_front #(
    .MAX_WORD (MAX_WORD),
    .IDX_W    (IDX_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_byte      (in_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_in_cmd),
    .rel          (rel),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  twn_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  twn_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .q_empty         (q_empty),
    .q_cmd           (q_out_cmd),
    .q_pop           (q_pop),
    .rel             (rel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  // Queue never written when full, never read when empty
  `TWN_ASSERT_IMP(a_no_overflow, q_push, !q_full)
  `TWN_ASSERT_IMP(a_no_underflow, q_pop, !q_empty)
  // A bank release ends a run: the last byte is then in the output register
  `TWN_ASSERT_NEXT(a_release_last, rel.valid, out_valid && out_last_of_run)

endmodule

FILE: tb/sv/text_word_normalizer_checker.sv
`timescale 1ns / 1ps

module text_word_normalizer_checker #(
  parameter int MAX_WORD = twn_pkg::MAX_WORD_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_operation,
  input  logic [twn_pkg::BYTE_W-1:0] in_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [twn_pkg::BYTE_W-1:0] out_byte,
  input  logic                       out_last_of_run,
  output int                         mismatch_count,
  output int                         bytes_owed
);

  import twn_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } norm_byte_t;

  // Bytes the block still owes, oldest first
  norm_byte_t owed_q[$];

  // Shadow of the current word and sentence state
  logic [BYTE_W-1:0] word_buf [MAX_WORD];
  logic [LEN_W-1:0]  word_len;
  logic              alpha_only;
  logic              word_long;
  logic              prior_word;
  int                run_len;

  function automatic twn_class_t byte_kind(input logic flush, input logic [BYTE_W-1:0] c);
    twn_class_t k;
    if (flush) begin
      k = CLS_FLUSH;
    end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                 (c >= "0" && c <= "9") || c == "@" || c == "$" || c == "#" ||
                 c == "+" || c == "<" || c == ">" || c == "=" || c == "/") begin
      k = CLS_ADD;
    end else if (c == " ") begin
      k = CLS_SPACE;
    end else if (c == ";" || c == "." || c == "!" || c == "?") begin
      k = CLS_SENT;
    end else begin
      k = CLS_SKIP;
    end
    return k;
  endfunction

  function automatic logic word_ok();
    return word_len != 0 && alpha_only && !word_long;
  endfunction

  task automatic put_byte(input logic [BYTE_W-1:0] ch);
    owed_q.push_back('{ch: ch, last: 1'b0});
    run_len++;
  endtask

  task automatic put_word();
    for (int i = 0; i < word_len; i++) begin
      put_byte(word_buf[i]);
    end
  endtask

  task automatic clear_word();
    word_len   = '0;
    alpha_only = 1'b1;
    word_long  = 1'b0;
  endtask

  // Work out the bytes one accepted item causes and queue them
  task automatic normalize_item(input logic flush, input logic [BYTE_W-1:0] c);
    twn_class_t        kind;
    logic [BYTE_W-1:0] lc;
    norm_byte_t        tail;
    run_len = 0;
    kind = byte_kind(flush, c);
    case (kind)
      CLS_FLUSH: begin
        if (word_len != 0) begin
          if (word_ok()) begin
            put_word();
            put_byte(" ");
            put_byte(".");
            put_byte(" ");
          end
        end else if (prior_word) begin
          put_byte(".");
          put_byte(" ");
        end
        clear_word();
        prior_word = 1'b0;
      end
      CLS_ADD: begin
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (lc < "a" || lc > "z") alpha_only = 1'b0;
        // drop bytes past the word limit and mark the word too long
        if (word_len >= MAX_WORD) begin
          word_long = 1'b1;
        end else begin
          word_buf[word_len] = lc;
          word_len = word_len + 1'b1;
        end
      end
      CLS_SPACE: begin
        if (word_ok()) begin
          put_word();
          put_byte(" ");
          prior_word = 1'b1;
        end
        clear_word();
      end
      CLS_SENT: begin
        if (word_ok()) begin
          put_word();
          put_byte(" ");
          put_byte(".");
          put_byte(" ");
          prior_word = 1'b0;
        end else if (prior_word) begin
          put_byte(".");
          put_byte(" ");
          prior_word = 1'b0;
        end
        clear_word();
      end
      default: ;
    endcase
    // flag the final byte of this run
    if (run_len > 0) begin
      tail = owed_q.pop_back();
      tail.last = 1'b1;
      owed_q.push_back(tail);
    end
  endtask

  task automatic report(input string what, input norm_byte_t want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.ch, want.last, out_byte, out_last_of_run);
    end
  endtask

  // Check results first, then predict, so a same-edge input never feeds its own result
  always @(posedge clk) begin
    norm_byte_t want;
    if (!rst_n) begin
      clear_word();
      prior_word = 1'b0;
      owed_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          report("unexpected transfer", '0);
        end else begin
          want = owed_q.pop_front();
          if (out_byte !== want.ch || out_last_of_run !== want.last) begin
            report("result mismatch", want);
          end
        end
      end
      if (in_valid && !in_stall) begin
        normalize_item(in_operation, in_byte);
      end
    end
    bytes_owed = owed_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import twn_pkg::*;

  localparam logic OP_TEXT  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int RANDOM_ITEMS  = 270;
  localparam int PHASE_TWO_AT  = 90;
  localparam int PHASE_3_AT    = 180;
  localparam int HOLD_AT       = 200;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 80;

  // Opening sequence: extremes, skipped bytes and each sentence/flush case
  localparam logic [8:0] OPENING [24] = '{
    {OP_TEXT, "A"}, {OP_TEXT, "z"}, {OP_TEXT, " "},
    {OP_TEXT, "0"}, {OP_TEXT, "."},
    {OP_TEXT, "."},
    {OP_TEXT, "Z"}, {OP_TEXT, 8'h00}, {OP_TEXT, 8'hFF}, {OP_TEXT, 8'h7F},
    {OP_TEXT, "a"}, {OP_TEXT, "!"},
    {OP_TEXT, "#"}, {OP_FLUSH, 8'h00},
    {OP_TEXT, "q"}, {OP_TEXT, " "}, {OP_FLUSH, 8'hFF},
    {OP_FLUSH, 8'h55},
    {OP_TEXT, "m"}, {OP_FLUSH, 8'hAA},
    {OP_TEXT, "?"}, {OP_TEXT, ";"}, {OP_TEXT, ","}, {OP_FLUSH, 8'hFF}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_operation;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last_of_run;

  int   mismatch_count;
  int   bytes_owed;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   random_count;
  logic hold_off;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  text_word_normalizer_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  text_word_normalizer_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .mismatch_count  (mismatch_count),
    .bytes_owed      (bytes_owed)
  );

  // Stall the result channel at random, or solid during a hold-off
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hold off the receiver long enough for the block to back up into its input
  initial begin
    hold_off = 1'b0;
    wait (random_count >= HOLD_AT);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("text_word_normalizer_unit test failed");
    $finish;
  end

  // Offer one item after random idle cycles; return at the falling edge after the transfer
  task automatic send_item(input logic op, input logic [BYTE_W-1:0] b, input bit counted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_operation <= 1'($urandom_range(0, 1));
      in_byte      <= 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_byte      <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (counted) random_count++;
  endtask

  function automatic logic [BYTE_W-1:0] rand_letter();
    logic [BYTE_W-1:0] b;
    b = 8'("a" + $urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) b = b - 8'd32;
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_symbol();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 9))
      0:       b = "@";
      1:       b = "$";
      2:       b = "#";
      3:       b = "+";
      4:       b = "<";
      5:       b = ">";
      6:       b = "=";
      7:       b = "/";
      default: b = 8'("0" + $urandom_range(0, 9));
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_skip();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 5))
      0:       b = 8'($urandom_range(0, 31));
      1:       b = 8'h7F;
      2:       b = 8'($urandom_range(128, 255));
      3:       b = "'";
      4:       b = "\"";
      default: b = ",";
    endcase
    return b;
  endfunction

  // Close a word: mostly a space, sometimes a sentence end or a flush
  task automatic send_separator();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      send_item(OP_TEXT, " ", 1'b1);
    end else if (pick < 90) begin
      case ($urandom_range(0, 3))
        0:       send_item(OP_TEXT, ";", 1'b1);
        1:       send_item(OP_TEXT, ".", 1'b1);
        2:       send_item(OP_TEXT, "!", 1'b1);
        default: send_item(OP_TEXT, "?", 1'b1);
      endcase
    end else begin
      send_item(OP_FLUSH, 8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int kind;
    int len;
    int waited;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_TEXT;
    in_byte       = '0;
    send_idle_pct = 38;
    recv_idle_pct = 54;
    random_count  = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (OPENING[i]) begin
      send_item(OPENING[i][8], OPENING[i][7:0], 1'b0);
    end

    // Longest valid word into a sentence end, then one letter past the limit
    for (int i = 0; i < u_checker.MAX_WORD; i++) send_item(OP_TEXT, rand_letter(), 1'b1);
    send_item(OP_TEXT, ".", 1'b1);
    for (int i = 0; i <= u_checker.MAX_WORD; i++) send_item(OP_TEXT, rand_letter(), 1'b1);
    send_item(OP_TEXT, " ", 1'b1);

    while (random_count < RANDOM_ITEMS) begin
      // Shift idling between the two sides, then run at full rate
      if (random_count < PHASE_TWO_AT) begin
        send_idle_pct = 38;
        recv_idle_pct = 54;
      end else if (random_count < PHASE_3_AT) begin
        send_idle_pct = 54;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // plain word, now and then near the length limit
        len = ($urandom_range(0, 9) == 0) ?
              $urandom_range(u_checker.MAX_WORD - 2, u_checker.MAX_WORD + 2) :
              $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_item(OP_TEXT, rand_letter(), 1'b1);
        send_separator();
      end else if (kind < 80) begin
        // word with digits, symbols and skipped bytes mixed in
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 19))
            0, 1, 2:       send_item(OP_TEXT, rand_skip(), 1'b0);
            3, 4, 5, 6, 7: send_item(OP_TEXT, rand_symbol(), 1'b1);
            default:       send_item(OP_TEXT, rand_letter(), 1'b1);
          endcase
        end
        send_separator();
      end else if (kind < 92) begin
        send_separator();
      end else begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
      end
    end
    in_valid <= 1'b0;

    // Drain every owed byte, then give the back end time to show anything extra
    waited = 0;
    while (bytes_owed != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && bytes_owed == 0) begin
      $display("text_word_normalizer_unit test passed");
    end else begin
      $display("text_word_normalizer_unit test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/twn_pkg.sv
sv/twn_fifo.sv
sv/twn_front.sv
sv/twn_back.sv
sv/text_word_normalizer_unit.sv
tb/sv/text_word_normalizer_checker.sv
tb/sv/tb_top.sv
